### src/wbwd_pkg.sv
// Package for the wide-by-word divider: field widths, pipeline sizing constants
// and the packed transfer and pipeline stage types. No dependencies.
`timescale 1ns / 1ps

package wbwd_pkg;

  localparam int unsigned DIVIDEND_W           = 128;
  localparam int unsigned HALF_W               = 64;
  localparam int unsigned DIVISOR_W            = 32;
  localparam int unsigned WBWD_STEPS_PER_STAGE = 8;

  typedef struct packed {
    logic [HALF_W-1:0]    dividend_high;
    logic [HALF_W-1:0]    dividend_low;
    logic [DIVISOR_W-1:0] divisor;
  } wbwd_in_t;

  typedef struct packed {
    logic [HALF_W-1:0]    quotient_high;
    logic [HALF_W-1:0]    quotient_low;
    logic [DIVISOR_W-1:0] remainder;
    logic                 divide_by_zero;
  } wbwd_out_t;

  // Partial remainder, plus a word that shifts dividend bits out at the top
  // while quotient bits enter at the bottom.
  typedef struct packed {
    logic                  valid;
    logic                  dbz;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVIDEND_W-1:0] dq;
  } wbwd_pipe_t;

endpackage

### src/wbwd_stage.sv
// One registered pipeline stage of the restoring divider: a fixed number of
// shift, compare and subtract steps. Depends on wbwd_pkg.
`timescale 1ns / 1ps

module wbwd_stage #(
  parameter int unsigned STEPS = wbwd_pkg::WBWD_STEPS_PER_STAGE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wbwd_pkg::wbwd_pipe_t pipe_in,
  output wbwd_pkg::wbwd_pipe_t pipe_out
);
  import wbwd_pkg::*;

  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] dq_nxt;
  logic [DIVISOR_W:0]    trial;

  logic                  valid_r;
  logic                  dbz_r;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] dq_r;

  always_comb begin
    rem_nxt = pipe_in.rem;
    dq_nxt  = pipe_in.dq;
    trial   = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_nxt, dq_nxt[DIVIDEND_W-1]};
      if (trial >= {1'b0, pipe_in.divisor}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, pipe_in.divisor});
        dq_nxt  = {dq_nxt[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
        dq_nxt  = {dq_nxt[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pipe_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    dbz_r     <= pipe_in.dbz;
    divisor_r <= pipe_in.divisor;
    rem_r     <= rem_nxt;
    dq_r      <= dq_nxt;
  end

  assign pipe_out = '{valid: valid_r, dbz: dbz_r, divisor: divisor_r,
                      rem: rem_r, dq: dq_r};

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_in.valid && !pipe_in.dbz && pipe_in.rem < pipe_in.divisor)
      |=> (rem_r < divisor_r))
    else $error("Partial remainder reached the divisor.");

  a_dbz_follows_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_in.valid && (pipe_in.dbz == (pipe_in.divisor == '0)))
      |=> (dbz_r == (divisor_r == '0)))
    else $error("Zero flag lost track of the divisor.");

  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(pipe_in.valid))
    else $error("Stage valid without an upstream transfer.");
`endif

endmodule

### src/wide_by_word_divider.sv
// Top level of the pipelined unsigned 128-by-32-bit divider.
// Depends on wbwd_pkg and wbwd_stage.
//
// Usage: a transfer is taken at a rising edge with start high and busy low.
// busy is always low, so a new division may start in every cycle.
// in_data carries the two dividend halves and the divisor.
// The result appears on out_data for exactly one cycle, marked by out_valid.
// Throughput is one division per cycle; the latency is set by the chain of
// stages, each running STEPS_PER_STAGE restoring shift-subtract steps.
// Results leave in the order their transfers were taken.
// A zero divisor sets divide_by_zero, gives an all-ones quotient and passes
// the low 32 dividend bits as the remainder.
// Reset clears every stage valid bit, so divisions in flight are dropped.
// The receiver cannot stall: each result must be taken in its strobe cycle.
`timescale 1ns / 1ps

module wide_by_word_divider #(
  parameter int unsigned STEPS_PER_STAGE = wbwd_pkg::WBWD_STEPS_PER_STAGE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wbwd_pkg::wbwd_in_t  in_data,
  output logic                out_valid,
  output wbwd_pkg::wbwd_out_t out_data
);
  import wbwd_pkg::*;

  localparam int unsigned NUM_STAGES = DIVIDEND_W / STEPS_PER_STAGE;

  wbwd_pipe_t pipe [NUM_STAGES+1];

  assign busy = 1'b0;

  assign pipe[0] = '{valid:   start && !busy,
                     dbz:     (in_data.divisor == '0),
                     divisor: in_data.divisor,
                     rem:     '0,
                     dq:      {in_data.dividend_high, in_data.dividend_low}};

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    wbwd_stage #(
      .STEPS(STEPS_PER_STAGE)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .pipe_in (pipe[s]),
      .pipe_out(pipe[s+1])
    );
  end

  assign out_valid = pipe[NUM_STAGES].valid;
  assign out_data  = '{quotient_high:  pipe[NUM_STAGES].dq[DIVIDEND_W-1:HALF_W],
                       quotient_low:   pipe[NUM_STAGES].dq[HALF_W-1:0],
                       remainder:      pipe[NUM_STAGES].rem,
                       divide_by_zero: pipe[NUM_STAGES].dbz};

`ifndef NO_ASSERTIONS
  a_result_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, NUM_STAGES))
    else $error("Result strobe without a matching transfer.");

  a_zero_quotient_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_by_zero)
      |-> (out_data.quotient_high == '1 && out_data.quotient_low == '1))
    else $error("Zero divisor result is not all ones.");

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.divide_by_zero)
      |-> (out_data.remainder < $past(in_data.divisor, NUM_STAGES)))
    else $error("Remainder is not below the divisor.");
`endif

endmodule

### dv/tb_wide_by_word_divider.sv
// Self-checking testbench for the wide_by_word_divider 128-by-32-bit unsigned divider.
// It runs a directed table and then random divisions, and checks each result in order.
// Depends on wbwd_pkg and the divider RTL.
`timescale 1ns / 1ps

module tb_wide_by_word_divider;
  import wbwd_pkg::*;

  typedef struct {
    wbwd_in_t  stim;
    bit        known;
    wbwd_out_t want;
  } div_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  wbwd_in_t  in_data;
  logic      out_valid;
  wbwd_out_t out_data;

  bit        drv_known;
  wbwd_out_t drv_want;
  wbwd_out_t pending_quotients[$];
  div_row_t  div_rows[$];
  int        errors;

  wide_by_word_divider u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wbwd_out_t quotient_of(wbwd_in_t a);
    logic [DIVIDEND_W-1:0] num;
    logic [DIVIDEND_W-1:0] den;
    logic [DIVIDEND_W-1:0] quo;
    logic [DIVIDEND_W-1:0] rem;
    wbwd_out_t             r;
    if (a.divisor == '0) begin
      r.quotient_high  = '1;
      r.quotient_low   = '1;
      r.remainder      = a.dividend_low[DIVISOR_W-1:0];
      r.divide_by_zero = 1'b1;
    end else begin
      num = {a.dividend_high, a.dividend_low};
      den = {{(DIVIDEND_W-DIVISOR_W){1'b0}}, a.divisor};
      quo = num / den;
      rem = num % den;
      r.quotient_high  = quo[DIVIDEND_W-1:HALF_W];
      r.quotient_low   = quo[HALF_W-1:0];
      r.remainder      = rem[DIVISOR_W-1:0];
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  function automatic wbwd_in_t random_division();
    wbwd_in_t x;
    x.dividend_high = {$urandom, $urandom};
    x.dividend_low  = {$urandom, $urandom};
    case ($urandom_range(7))
      0: x.dividend_high = '0;
      1: x.dividend_high = {32'd0, $urandom};
      2: begin
        x.dividend_high = '1;
        x.dividend_low  = '1;
      end
      3: x.dividend_low = '0;
      default: ;
    endcase
    case ($urandom_range(15))
      0: x.divisor = '0;
      1: x.divisor = 32'hffff_ffff - $urandom_range(3);
      2: x.divisor = 32'd1 << $urandom_range(31);
      3, 4: x.divisor = $urandom_range(1, 255);
      default: begin
        x.divisor = $urandom;
        if (x.divisor == '0) x.divisor = 32'd1;
      end
    endcase
    return x;
  endfunction

  task automatic add_row(logic [63:0] hi, logic [63:0] lo, logic [31:0] d, bit known,
                         logic [63:0] qh, logic [63:0] ql, logic [31:0] r, logic z);
    div_row_t row;
    row.stim.dividend_high = hi;
    row.stim.dividend_low  = lo;
    row.stim.divisor       = d;
    row.known              = known;
    row.want.quotient_high = qh;
    row.want.quotient_low  = ql;
    row.want.remainder     = r;
    row.want.divide_by_zero = z;
    div_rows.push_back(row);
  endtask

  task automatic send_division(wbwd_in_t x, bit known, wbwd_out_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   = 1'b0;
      in_data = random_division();
      @(negedge clk);
    end
    start     = 1'b1;
    in_data   = x;
    drv_known = known;
    drv_want  = want;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    wbwd_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_quotients.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = pending_quotients.pop_front();
          check_field("quotient_high", want.quotient_high, out_data.quotient_high);
          check_field("quotient_low", want.quotient_low, out_data.quotient_low);
          check_field("remainder", 64'(want.remainder), 64'(out_data.remainder));
          check_field("divide_by_zero", 64'(want.divide_by_zero), 64'(out_data.divide_by_zero));
        end
      end
      if (start && !busy) begin
        pending_quotients.push_back(drv_known ? drv_want : quotient_of(in_data));
      end
    end
  end

  initial begin
    int idle_pct[3];
    idle_pct  = '{37, 76, 0};
    errors    = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    drv_known = 1'b0;
    drv_want  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(64'd0, 64'd0, 32'd1, 1, 64'd0, 64'd0, 32'd0, 1'b0);
    add_row('1, '1, 32'd1, 1, '1, '1, 32'd0, 1'b0);
    add_row(64'd0, 64'd0, 32'd0, 1, '1, '1, 32'd0, 1'b1);
    add_row('1, '1, 32'd0, 1, '1, '1, 32'hffff_ffff, 1'b1);
    add_row(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd0, 1,
            '1, '1, 32'h7654_3210, 1'b1);
    add_row(64'd0, 64'd1, 32'hffff_ffff, 1, 64'd0, 64'd0, 32'd1, 1'b0);
    add_row(64'd0, 64'hffff_ffff, 32'hffff_ffff, 1, 64'd0, 64'd1, 32'd0, 1'b0);
    add_row(64'd0, 64'hffff_fffe, 32'hffff_ffff, 1, 64'd0, 64'd0, 32'hffff_fffe, 1'b0);
    add_row(64'h8000_0000_0000_0000, 64'd0, 32'd2, 1,
            64'h4000_0000_0000_0000, 64'd0, 32'd0, 1'b0);
    add_row(64'd0, '1, 32'd2, 1, 64'd0, 64'h7fff_ffff_ffff_ffff, 32'd1, 1'b0);
    add_row('1, '1, 32'hffff_ffff, 0, '0, '0, '0, 1'b0);
    add_row('1, '1, 32'h8000_0000, 0, '0, '0, '0, 1'b0);
    add_row(64'h0000_0000_ffff_fffe, '1, 32'hffff_ffff, 0, '0, '0, '0, 1'b0);
    add_row(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 32'd3, 0, '0, '0, '0, 1'b0);
    add_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaab, 0,
            '0, '0, '0, 1'b0);
    add_row(64'd1, 64'd0, 32'h0001_0000, 0, '0, '0, '0, 1'b0);

    foreach (div_rows[i]) send_division(div_rows[i].stim, div_rows[i].known,
                                        div_rows[i].want, idle_pct[0]);
    for (int ph = 0; ph < 3; ph++) begin
      repeat (145) send_division(random_division(), 1'b0, '0, idle_pct[ph]);
    end
    start = 1'b0;

    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
